// ===== rtl/utf8_byte_stream_decoder_core_defines.svh =====
// assertion macros shared by the decoder rtl
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define UBSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ubsd assertion failed");
`define UBSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ubsd assertion failed");
`else
`define UBSD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define UBSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ubsd_pkg.sv =====
package ubsd_pkg;

   localparam int CP_W = 21;
   localparam logic [CP_W-1:0] QMARK = CP_W'(63);

   localparam logic [2:0] LEN_BAD   = 3'd0;
   localparam logic [2:0] LEN_ASCII = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic       load;
      logic [1:0] sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] count;
   } dp_status_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80) begin
         n = LEN_ASCII;
      end else if ((b & 8'hE0) == 8'hC0) begin
         n = LEN_TWO;
      end else if ((b & 8'hF0) == 8'hE0) begin
         n = LEN_THREE;
      end else if ((b & 8'hF8) == 8'hF0) begin
         n = LEN_FOUR;
      end else begin
         n = LEN_BAD;
      end
      return n;
   endfunction

   // a byte standing alone at the text end
   function automatic logic [CP_W-1:0] single_cp(input logic [7:0] b);
      logic [CP_W-1:0] v;
      if (b < 8'h80) begin
         v = {{(CP_W-8){1'b0}}, b};
      end else begin
         v = QMARK;
      end
      return v;
   endfunction

endpackage

// ===== rtl/ubsd_if.sv =====
interface ubsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       text_last;

   modport source (output valid, output data_byte, output text_last, input ready);
   modport sink (input valid, input data_byte, input text_last, output ready);
endinterface

interface ubsd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ubsd_pkg::CP_W-1:0] code_point;
   logic                      run_end;

   modport source (output valid, output code_point, output run_end, input ready);
   modport sink (input valid, input code_point, input run_end, output ready);
endinterface

// ===== rtl/utf8_byte_stream_decoder_core.sv =====
// UTF-8 byte stream decoder: takes one byte per request with a flag on the
// final byte of a text and returns code points, '?' for a bad or cut-short
// lead. A new byte is taken every cycle while no result waits or the last
// is taken; a byte that only extends a sequence returns nothing. A final
// byte that cuts a sequence short returns two or three results, one per cycle
// from the result register while the receiver is ready, and the next byte
// waits until the last of them is taken. No clearing pass is needed after reset.
module utf8_byte_stream_decoder_core (
   input  logic       clock,
   input  logic       reset,
   ubsd_req_if.sink   req_chan,
   ubsd_rsp_if.source rsp_chan
);

   ubsd_pkg::ctrl_cmd_type  cmd;
   ubsd_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    rsp_run_end;
   logic [ubsd_pkg::CP_W-1:0] rsp_code_point;

   ubsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_run_end (rsp_run_end),
      .cmd         (cmd),
      .status      (status)
   );

   ubsd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .data_byte  (req_chan.data_byte),
      .text_last  (req_chan.text_last),
      .code_point (rsp_code_point)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.code_point = rsp_code_point;
   assign rsp_chan.run_end    = rsp_run_end;

endmodule

// ===== rtl/ubsd_datapath.sv =====
`include "utf8_byte_stream_decoder_core_defines.svh"

module ubsd_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ubsd_pkg::ctrl_cmd_type    cmd,
   output ubsd_pkg::dp_status_type   status,
   input  logic [7:0]                data_byte,
   input  logic                      text_last,
   output logic [ubsd_pkg::CP_W-1:0] code_point
);

   logic [7:0]                held0_ff, held1_ff, held2_ff;
   logic [7:0]                held0_in, held1_in, held2_in;
   logic [1:0]                held_count_ff, held_count_in;
   logic [2:0]                seq_len_ff, seq_len_in;
   logic [ubsd_pkg::CP_W-1:0] res0_ff, res1_ff, res2_ff;
   logic [ubsd_pkg::CP_W-1:0] res0_in, res1_in, res2_in;
   logic [1:0]                count;
   logic [2:0]                n;
   logic [2:0]                n_held1;

   assign n       = ubsd_pkg::lead_len(data_byte);
   assign n_held1 = ubsd_pkg::lead_len(held1_ff);

   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held2_in      = held2_ff;
      held_count_in = held_count_ff;
      seq_len_in    = seq_len_ff;
      res0_in       = ubsd_pkg::QMARK;
      res1_in       = ubsd_pkg::QMARK;
      res2_in       = ubsd_pkg::QMARK;
      count         = 2'd0;
      if (seq_len_ff == 3'd0) begin
         if (n == ubsd_pkg::LEN_ASCII) begin
            res0_in = {{(ubsd_pkg::CP_W-8){1'b0}}, data_byte};
            count   = 2'd1;
         end else if ((n == ubsd_pkg::LEN_BAD) || text_last) begin
            count = 2'd1;
         end else begin
            held0_in      = data_byte;
            held_count_in = 2'd1;
            seq_len_in    = n;
         end
      end else if ((3'(held_count_ff) + 3'd1) >= seq_len_ff) begin
         // sequence complete
         case (held_count_ff)
            2'd1: res0_in = {10'b0, held0_ff[4:0], data_byte[5:0]};
            2'd2: res0_in = {5'b0, held0_ff[3:0], held1_ff[5:0], data_byte[5:0]};
            2'd3: res0_in = {held0_ff[2:0], held1_ff[5:0], held2_ff[5:0], data_byte[5:0]};
            default: res0_in = {{(ubsd_pkg::CP_W-8){1'b0}}, data_byte};
         endcase
         count         = 2'd1;
         held_count_in = 2'd0;
         seq_len_in    = 3'd0;
      end else if (!text_last) begin
         case (held_count_ff)
            2'd0: held0_in = data_byte;
            2'd1: held1_in = data_byte;
            default: held2_in = data_byte;
         endcase
         held_count_in = held_count_ff + 2'd1;
      end else begin
         // truncated at text end: lead gives '?', tail decoded again
         if (held_count_ff == 2'd2) begin
            if (n_held1 == ubsd_pkg::LEN_ASCII) begin
               res1_in = {{(ubsd_pkg::CP_W-8){1'b0}}, held1_ff};
               res2_in = ubsd_pkg::single_cp(data_byte);
               count   = 2'd3;
            end else if (n_held1 == ubsd_pkg::LEN_TWO) begin
               res1_in = {10'b0, held1_ff[4:0], data_byte[5:0]};
               count   = 2'd2;
            end else begin
               res2_in = ubsd_pkg::single_cp(data_byte);
               count   = 2'd3;
            end
         end else begin
            res1_in = ubsd_pkg::single_cp(data_byte);
            count   = 2'd2;
         end
         held_count_in = 2'd0;
         seq_len_in    = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
      end else if (cmd.load) begin
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
         res0_ff  <= res0_in;
         res1_ff  <= res1_in;
         res2_ff  <= res2_in;
      end
   end

   always_comb begin
      case (cmd.sel)
         2'd0: code_point = res0_ff;
         2'd1: code_point = res1_ff;
         default: code_point = res2_ff;
      endcase
   end

   assign status.count = count;

   `UBSD_ASSERT_IMPL(a_open_count, clock, reset, seq_len_ff != 3'd0, (held_count_ff != 2'd0) && (3'(held_count_ff) < seq_len_ff))
   `UBSD_ASSERT_IMPL(a_closed_empty, clock, reset, seq_len_ff == 3'd0, held_count_ff == 2'd0)

endmodule

// ===== rtl/ubsd_ctrl.sv =====
`include "utf8_byte_stream_decoder_core_defines.svh"

module ubsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_run_end,
   output ubsd_pkg::ctrl_cmd_type  cmd,
   input  ubsd_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_OUT  = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       is_last;
   logic       accept;

   assign is_last     = (pos_ff == (cnt_ff - 2'd1));
   assign req_ready   = (state_ff == ST_IDLE) || (rsp_ready && is_last);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = (state_ff == ST_OUT);
   assign rsp_run_end = is_last;
   assign cmd.load    = accept;
   assign cmd.sel     = pos_ff;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (status.count != 2'd0)) begin
               state_in = ST_OUT;
               pos_in   = 2'd0;
               cnt_in   = status.count;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (is_last) begin
                  if (accept && (status.count != 2'd0)) begin
                     pos_in = 2'd0;
                     cnt_in = status.count;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= 2'd0;
         cnt_ff   <= 2'd1;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   `UBSD_ASSERT_IMPL(a_pos_range, clock, reset, state_ff == ST_OUT, (cnt_ff != 2'd0) && (pos_ff < cnt_ff))
   `UBSD_ASSERT_IMPL(a_accept_on_last, clock, reset, accept && (state_ff == ST_OUT), rsp_ready && is_last)
   `UBSD_ASSERT_NEXT(a_silent_idle, clock, reset, accept && (status.count == 2'd0), state_ff == ST_IDLE)

endmodule

// ===== tb/tb_utf8_decode_checker.sv =====
module tb_utf8_decode_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_text_last,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [ubsd_pkg::CP_W-1:0] rsp_code_point,
   input  logic                      rsp_run_end,
   output int                        fail_count,
   output int                        points_due
);

   typedef struct packed {
      logic [ubsd_pkg::CP_W-1:0] code_point;
      logic                      run_end;
   } point_type;

   point_type  expected_points[$];
   logic [7:0] held[3];
   logic [1:0] held_cnt;
   logic [2:0] seq_len;

   initial begin
      fail_count = 0;
      points_due = 0;
   end

   function automatic logic [2:0] byte_class(input logic [7:0] b);
      logic [2:0] c;
      casez (b)
         8'b0???????: c = ubsd_pkg::LEN_ASCII;
         8'b110?????: c = ubsd_pkg::LEN_TWO;
         8'b1110????: c = ubsd_pkg::LEN_THREE;
         8'b11110???: c = ubsd_pkg::LEN_FOUR;
         default:     c = ubsd_pkg::LEN_BAD;
      endcase
      return c;
   endfunction

   function automatic logic [ubsd_pkg::CP_W-1:0] merge_bytes(input logic [3:0][7:0] s,
                                                             input int n);
      logic [ubsd_pkg::CP_W-1:0] v;
      int k;
      v = '0;
      case (n)
         2: v[4:0] = s[0][4:0];
         3: v[3:0] = s[0][3:0];
         default: v[2:0] = s[0][2:0];
      endcase
      for (k = 1; k < n; k++) begin
         v = {v[ubsd_pkg::CP_W-7:0], s[k][5:0]};
      end
      return v;
   endfunction

   function automatic logic [ubsd_pkg::CP_W-1:0] ascii_point(input logic [7:0] b);
      logic [ubsd_pkg::CP_W-1:0] v;
      v = '0;
      v[7:0] = b;
      return v;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [ubsd_pkg::CP_W-1:0] res[3];
      logic [3:0][7:0]           seq;
      logic [7:0]                tail[3];
      logic [2:0]                cls;
      int                        cnt;
      int                        tlen;
      int                        pos;
      int                        k;
      point_type                 p;
      cnt = 0;
      if (seq_len == 3'd0) begin
         cls = byte_class(b);
         if (cls == ubsd_pkg::LEN_ASCII) begin
            res[cnt] = ascii_point(b);
            cnt += 1;
         end else if (cls == ubsd_pkg::LEN_BAD || last) begin
            res[cnt] = ubsd_pkg::QMARK;
            cnt += 1;
         end else begin
            held[0] = b;
            held_cnt = 2'd1;
            seq_len = cls;
         end
      end else if (int'(held_cnt) + 1 >= int'(seq_len)) begin
         seq = '0;
         for (k = 0; k < int'(held_cnt); k++) seq[k] = held[k];
         seq[held_cnt] = b;
         res[cnt] = merge_bytes(seq, int'(held_cnt) + 1);
         cnt += 1;
         held_cnt = 2'd0;
         seq_len = 3'd0;
      end else if (!last) begin
         held[held_cnt] = b;
         held_cnt = held_cnt + 2'd1;
      end else begin
         // cut short: '?' for the lead, then the rest decoded as a text of its own
         res[cnt] = ubsd_pkg::QMARK;
         cnt += 1;
         tlen = 0;
         for (k = 1; k < int'(held_cnt); k++) begin
            tail[tlen] = held[k];
            tlen += 1;
         end
         tail[tlen] = b;
         tlen += 1;
         pos = 0;
         while (pos < tlen && cnt < 3) begin
            cls = byte_class(tail[pos]);
            if (cls == ubsd_pkg::LEN_ASCII) begin
               res[cnt] = ascii_point(tail[pos]);
               pos += 1;
            end else if (cls >= ubsd_pkg::LEN_TWO && pos + int'(cls) - 1 < tlen) begin
               seq = '0;
               for (k = 0; k < int'(cls); k++) seq[k] = tail[pos + k];
               res[cnt] = merge_bytes(seq, int'(cls));
               pos += int'(cls);
            end else begin
               res[cnt] = ubsd_pkg::QMARK;
               pos += 1;
            end
            cnt += 1;
         end
         held_cnt = 2'd0;
         seq_len = 3'd0;
      end
      for (k = 0; k < cnt; k++) begin
         p.code_point = res[k];
         p.run_end = (k == cnt - 1);
         expected_points.insert(expected_points.size(), p);
      end
   endtask

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         held_cnt = 2'd0;
         seq_len = 3'd0;
         expected_points.delete();
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_text_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result: code_point %h run_end %b",
                      rsp_code_point, rsp_run_end);
               fail_count += 1;
            end else begin
               want = expected_points.pop_front();
               if (want.code_point !== rsp_code_point) begin
                  $error("code_point: expected %h, got %h",
                         want.code_point, rsp_code_point);
                  fail_count += 1;
               end
               if (want.run_end !== rsp_run_end) begin
                  $error("run_end: expected %b, got %b", want.run_end, rsp_run_end);
                  fail_count += 1;
               end
            end
         end
      end
      points_due = expected_points.size();
   end

endmodule

// ===== tb/tb_utf8_byte_stream_decoder_core.sv =====
module tb_utf8_byte_stream_decoder_core;

   localparam int ITEM_TARGET  = 280;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   points_due;
   int   cycle_count = 0;
   int   sent_count = 0;
   int   taken_count = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;
   bit   hold_rsp = 1'b0;

   ubsd_req_if req_chan();
   ubsd_rsp_if rsp_chan();

   utf8_byte_stream_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tb_utf8_decode_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_data_byte  (req_chan.data_byte),
      .req_text_last  (req_chan.text_last),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_code_point (rsp_chan.code_point),
      .rsp_run_end    (rsp_chan.run_end),
      .fail_count     (fail_count),
      .points_due     (points_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count += 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** utf8_byte_stream_decoder_core: FAILED **");
         $finish;
      end
   end

   function automatic int draw_wait(input bit on);
      return on ? int'($urandom_range(0, 16)) : 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_wait(req_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.text_last <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent_count += 1;
      if (sent_count % 40 == 0) req_idle_on = ($urandom_range(0, 2) != 0);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (points_due != 0) @(negedge clock);
   endtask

   // receiver
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = draw_wait(rsp_idle_on);
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
         taken_count += 1;
         if (taken_count % 30 == 0) rsp_idle_on = ($urandom_range(0, 2) != 0);
      end
   end

   // sender and verdict
   initial begin
      int         kind;
      int         n;
      int         m;
      int         k;
      bit         hold_done;
      bit         pause_done;
      logic [7:0] lead;
      logic       tail_last;
      hold_done = 1'b0;
      pause_done = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.text_last = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ascii extremes and bad leads
      send_byte(8'h00, 1'b0);  send_byte(8'h7F, 1'b1);
      send_byte(8'h80, 1'b0);  send_byte(8'hF8, 1'b0);  send_byte(8'hFF, 1'b1);
      // two byte completed on the final byte, then a three byte one
      send_byte(8'hDF, 1'b0);  send_byte(8'hBF, 1'b1);
      send_byte(8'hE2, 1'b0);  send_byte(8'h82, 1'b0);  send_byte(8'hAC, 1'b0);
      // largest code point
      send_byte(8'hF7, 1'b0);  send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
      // lead on the final byte
      send_byte(8'hC2, 1'b1);
      // cut short, tail is ascii
      send_byte(8'hE2, 1'b0);  send_byte(8'h41, 1'b1);
      // cut short, tail holds a short lead and a stray byte
      send_byte(8'hF0, 1'b0);  send_byte(8'hE2, 1'b0);  send_byte(8'h80, 1'b1);
      // cut short, tail merges
      send_byte(8'hF0, 1'b0);  send_byte(8'hC3, 1'b0);  send_byte(8'hA9, 1'b1);

      while (sent_count < ITEM_TARGET) begin
         if (!hold_done && sent_count >= 110) begin
            hold_rsp = 1'b1;
            req_idle_on = 1'b0;
            hold_done = 1'b1;
         end
         if (!pause_done && sent_count >= 200) begin
            drain_results();
            pause_done = 1'b1;
         end
         kind = $urandom_range(0, 9);
         n = $urandom_range(2, 4);
         case (n)
            2: lead = 8'hC0 | 8'($urandom_range(0, 31));
            3: lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
         endcase
         if (kind <= 1) begin
            send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
         end else if (kind <= 6) begin
            // lead and tail bytes (a tail byte is sometimes random), final byte sometimes ends the text
            tail_last = ($urandom_range(0, 3) == 0);
            send_byte(lead, 1'b0);
            for (k = 1; k < n; k++) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_byte(8'($urandom), (k == n - 1) && tail_last);
               end else begin
                  send_byte(8'h80 | 8'($urandom_range(0, 63)), (k == n - 1) && tail_last);
               end
            end
         end else if (kind == 7) begin
            // sequence cut short by the text end
            m = $urandom_range(0, n - 2);
            send_byte(lead, m == 0);
            for (k = 1; k <= m; k++) begin
               send_byte(8'($urandom), k == m);
            end
         end else begin
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** utf8_byte_stream_decoder_core: PASSED **");
      end else begin
         $display("** utf8_byte_stream_decoder_core: FAILED **");
      end
      $finish;
   end

endmodule
